// ===== sv/psc_pkg.sv =====
// Shared types and constants of the polarity switch controller.
package psc_pkg;

    typedef enum logic [2:0] {
        ST_NONE   = 3'd0,
        ST_POS    = 3'd1,
        ST_NEG    = 3'd2,
        ST_MOVING = 3'd3,
        ST_FAULT  = 3'd4
    } state_t;

    typedef enum logic [1:0] {
        CMD_AUTO = 2'd0,
        CMD_POS  = 2'd1,
        CMD_NEG  = 2'd2,
        CMD_IDLE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT    = 2'd0,
        CFG_MOVE_DELAY = 2'd1,
        CFG_FAULT_HOLD = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    localparam int unsigned CfgWidth = 32;
    localparam logic [CfgWidth-1:0] FaultHoldReset = 32'd5000;

    typedef struct packed {
        logic [1:0] command;
        logic       regulation_off;
    } in_item_t;

    typedef struct packed {
        logic [2:0] switch_state;
        logic       enabled;
        logic       automatic_res;
        logic       negative;
    } out_item_t;

    typedef struct packed {
        logic [CfgWidth-1:0] timeout_ticks;
        logic [CfgWidth-1:0] move_delay_ticks;
        logic [CfgWidth-1:0] fault_hold_ticks;
    } cfg_regs_t;

endpackage

// ===== sv/psc_cfg.sv =====
// Configuration register bank of the polarity switch controller.
module psc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [1:0]                      wr_index,
    input  logic [psc_pkg::CfgWidth-1:0]    wr_data,
    output psc_pkg::cfg_regs_t              cfg
);

    psc_pkg::cfg_regs_t cfg_reg;
    psc_pkg::cfg_regs_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (psc_pkg::cfg_index_t'(wr_index))
                psc_pkg::CFG_TIMEOUT:    cfg_next.timeout_ticks    = wr_data;
                psc_pkg::CFG_MOVE_DELAY: cfg_next.move_delay_ticks = wr_data;
                psc_pkg::CFG_FAULT_HOLD: cfg_next.fault_hold_ticks = wr_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks    <= '0;
            cfg_reg.move_delay_ticks <= '0;
            cfg_reg.fault_hold_ticks <= psc_pkg::FaultHoldReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/psc_step.sv =====
// Next-state and result logic for one tick of the polarity switch state machine.
module psc_step #(
    parameter int unsigned TIMER_BITS = 32
) (
    input  psc_pkg::cfg_regs_t       cfg,
    input  psc_pkg::in_item_t        item,
    input  psc_pkg::state_t          state_in,
    input  logic                     target_in,
    input  logic [TIMER_BITS-1:0]    timer_in,
    output psc_pkg::state_t          state_out,
    output logic                     target_out,
    output logic [TIMER_BITS-1:0]    timer_out,
    output psc_pkg::out_item_t       result
);

    localparam int unsigned CmpW =
        (TIMER_BITS > psc_pkg::CfgWidth) ? TIMER_BITS : psc_pkg::CfgWidth;

    psc_pkg::cmd_t           cmd;
    logic                    timeout_zero;
    logic [TIMER_BITS-1:0]   timer_inc;
    logic [CmpW-1:0]         timer_ext;
    logic [CmpW-1:0]         timeout_ext;
    logic [CmpW-1:0]         delay_ext;
    logic [CmpW-1:0]         hold_ext;
    logic                    enabled;

    assign cmd          = psc_pkg::cmd_t'(item.command);
    assign timeout_zero = (cfg.timeout_ticks == '0);
    assign timer_inc    = (timer_in == '1) ? timer_in : timer_in + TIMER_BITS'(1);
    assign timer_ext    = CmpW'(timer_inc);
    assign timeout_ext  = CmpW'(cfg.timeout_ticks);
    assign delay_ext    = CmpW'(cfg.move_delay_ticks);
    assign hold_ext     = CmpW'(cfg.fault_hold_ticks);

    always_comb begin
        state_out  = state_in;
        target_out = target_in;
        timer_out  = timer_in;
        case (state_in)
            psc_pkg::ST_NONE: begin
                timer_out = '0;
                if (item.regulation_off && !timeout_zero) begin
                    if (cmd == psc_pkg::CMD_AUTO || cmd == psc_pkg::CMD_POS) begin
                        state_out  = psc_pkg::ST_POS;
                        target_out = 1'b0;
                    end else if (cmd == psc_pkg::CMD_NEG) begin
                        state_out  = psc_pkg::ST_NEG;
                        target_out = 1'b1;
                    end
                end
            end
            psc_pkg::ST_POS: begin
                if (timeout_zero) begin
                    state_out = psc_pkg::ST_NONE;
                end else if (item.regulation_off
                             && (cmd == psc_pkg::CMD_NEG || target_in)) begin
                    target_out = 1'b1;
                    state_out  = psc_pkg::ST_MOVING;
                end
            end
            psc_pkg::ST_NEG: begin
                if (timeout_zero) begin
                    state_out = psc_pkg::ST_NONE;
                end else if (item.regulation_off
                             && (cmd == psc_pkg::CMD_POS || !target_in)) begin
                    target_out = 1'b0;
                    state_out  = psc_pkg::ST_MOVING;
                end
            end
            psc_pkg::ST_MOVING: begin
                // A timeout is checked first, so it always beats completion.
                if (timer_ext > timeout_ext) begin
                    timer_out = '0;
                    state_out = psc_pkg::ST_FAULT;
                end else if (timer_ext > delay_ext) begin
                    timer_out = '0;
                    state_out = target_in ? psc_pkg::ST_NEG : psc_pkg::ST_POS;
                end else begin
                    timer_out = timer_inc;
                end
            end
            psc_pkg::ST_FAULT: begin
                timer_out = timer_inc;
                if (timer_ext > hold_ext) begin
                    state_out = psc_pkg::ST_NONE;
                end
            end
            default: begin
                state_out = psc_pkg::ST_NONE;
                timer_out = '0;
            end
        endcase
    end

    assign enabled              = (state_out != psc_pkg::ST_NONE);
    assign result.switch_state  = state_out;
    assign result.enabled       = enabled;
    assign result.automatic_res = enabled && (cmd == psc_pkg::CMD_AUTO);
    assign result.negative      = (state_out == psc_pkg::ST_NEG);

endmodule

// ===== sv/polarity_switch_controller.sv =====
// Polarity switch controller top level: input register, tick update and result register.
// An input is held in the input register until the output is free or being taken.
// One transfer per cycle unless the output stalls, with a single tick update in between.
// Reset (synchronous, active low) returns the switch to none with a cleared timer,
// empties both registers and loads the register defaults; configuration is ready always.
module polarity_switch_controller #(
    parameter int unsigned TIMER_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  psc_pkg::in_item_t                s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output psc_pkg::out_item_t               m_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [psc_pkg::CfgWidth-1:0]     cfg_data
);

    psc_pkg::cfg_regs_t      cfg;
    logic                    in_valid_reg;
    psc_pkg::in_item_t       in_item_reg;
    logic                    out_valid_reg;
    psc_pkg::out_item_t      out_item_reg;
    psc_pkg::state_t         state_reg;
    psc_pkg::state_t         state_next;
    logic                    target_reg;
    logic                    target_next;
    logic [TIMER_BITS-1:0]   timer_reg;
    logic [TIMER_BITS-1:0]   timer_next;
    psc_pkg::out_item_t      result;
    logic                    advance;

    assign cfg_ready = 1'b1;

    psc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    psc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .cfg        (cfg),
        .item       (in_item_reg),
        .state_in   (state_reg),
        .target_in  (target_reg),
        .timer_in   (timer_reg),
        .state_out  (state_next),
        .target_out (target_next),
        .timer_out  (timer_next),
        .result     (result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= psc_pkg::ST_NONE;
            target_reg    <= 1'b0;
            timer_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
                target_reg    <= target_next;
                timer_reg     <= timer_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule
